FILE: rtl/ile_pkg.sv
package ile_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int DATA_W   = 32;
    localparam int OP_W     = 3;
    localparam int IDX_W    = 7;
    localparam int ST_W     = 2;
    localparam int CNT_W    = 7;
    localparam int IN_W     = 48;
    localparam int OUT_W    = 48;

    localparam logic [OP_W-1:0] OP_INSERT      = 3'd0;
    localparam logic [OP_W-1:0] OP_DELETE      = 3'd1;
    localparam logic [OP_W-1:0] OP_READ        = 3'd2;
    localparam logic [OP_W-1:0] OP_REPLACE     = 3'd3;
    localparam logic [OP_W-1:0] OP_APPEND      = 3'd4;
    localparam logic [OP_W-1:0] OP_REMOVE_LAST = 3'd5;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_BAD_INDEX = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY     = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL      = 2'd3;

    localparam logic [DATA_W-1:0] NONE_VALUE = {DATA_W{1'b1}};

    // broadcast to every cell of the row
    typedef struct packed {
        logic              ins;
        logic              del;
        logic              wr;
        logic [ADDR_W-1:0] pos;
        logic [ADDR_W-1:0] rd_pos;
        logic [DATA_W-1:0] data;
    } t_cell_ctl;

endpackage

FILE: rtl/indexed_list_engine_unit.sv
// result: registered into the output register in the cycle after the request is accepted
// throughput: one request per cycle while results are taken; all cells shift, load
// or hold in parallel; the read word is an or-reduce over the row in the same cycle
// reset: synchronous active-low; clears the item count and the output valid,
// cell contents stay undefined until written
module indexed_list_engine_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // op [2:0], index [9:3], value [41:10], zero fill above
    input  logic [ile_pkg::IN_W-1:0]    i_s_axis_tdata,
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    // result_value [31:0], status [33:32], count [40:34], zero fill above
    output logic [ile_pkg::OUT_W-1:0]   o_m_axis_tdata
);

    logic [ile_pkg::OP_W-1:0]   w_op;
    logic [ile_pkg::IDX_W-1:0]  w_idx;
    logic [ile_pkg::DATA_W-1:0] w_val;
    logic                       w_acc;
    logic                       w_full;
    logic                       w_empty;

    logic [ile_pkg::CNT_W-1:0]  r_count;
    logic [ile_pkg::CNT_W-1:0]  n_count;
    logic                       r_out_valid;
    logic [ile_pkg::OUT_W-1:0]  r_out_data;

    logic [ile_pkg::DATA_W-1:0] w_res;
    logic [ile_pkg::ST_W-1:0]   w_st;
    logic [ile_pkg::DATA_W-1:0] w_sel;
    ile_pkg::t_cell_ctl         w_ctl;

    logic [ile_pkg::DATA_W-1:0] w_cell_data [ile_pkg::CAPACITY];
    logic [ile_pkg::DATA_W-1:0] w_cell_hit  [ile_pkg::CAPACITY];

    assign w_op  = i_s_axis_tdata[2:0];
    assign w_idx = i_s_axis_tdata[9:3];
    assign w_val = i_s_axis_tdata[41:10];

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign w_acc           = i_s_axis_tvalid && o_s_axis_tready;

    assign w_full  = (r_count == ile_pkg::CNT_W'(ile_pkg::CAPACITY));
    assign w_empty = (r_count == '0);

    always_comb begin
        w_sel = '0;
        for (int k = 0; k < ile_pkg::CAPACITY; k++) begin
            w_sel = w_sel | w_cell_hit[k];
        end
    end

    always_comb begin
        w_ctl.ins    = 1'b0;
        w_ctl.del    = 1'b0;
        w_ctl.wr     = 1'b0;
        w_ctl.pos    = ile_pkg::ADDR_W'(w_idx);
        w_ctl.data   = w_val;
        // remove last reads the top item, the others read at the index
        w_ctl.rd_pos = (w_op == ile_pkg::OP_REMOVE_LAST)
                     ? ile_pkg::ADDR_W'(r_count - ile_pkg::CNT_W'(1))
                     : ile_pkg::ADDR_W'(w_idx);
        w_res   = ile_pkg::NONE_VALUE;
        w_st    = ile_pkg::ST_OK;
        n_count = r_count;
        case (w_op)
            ile_pkg::OP_INSERT: begin
                if (w_idx > r_count) begin
                    w_st = ile_pkg::ST_BAD_INDEX;
                end else if (w_full) begin
                    w_st = ile_pkg::ST_FULL;
                end else begin
                    w_ctl.ins = w_acc;
                    n_count   = r_count + ile_pkg::CNT_W'(1);
                end
            end
            ile_pkg::OP_DELETE: begin
                if (w_empty) begin
                    w_st = ile_pkg::ST_EMPTY;
                end else if (w_idx >= r_count) begin
                    w_st = ile_pkg::ST_BAD_INDEX;
                end else begin
                    w_ctl.del = w_acc;
                    w_res     = w_sel;
                    n_count   = r_count - ile_pkg::CNT_W'(1);
                end
            end
            ile_pkg::OP_READ: begin
                if (w_empty) begin
                    w_st = ile_pkg::ST_EMPTY;
                end else if (w_idx >= r_count) begin
                    w_st = ile_pkg::ST_BAD_INDEX;
                end else begin
                    w_res = w_sel;
                end
            end
            ile_pkg::OP_REPLACE: begin
                if (w_empty) begin
                    w_st = ile_pkg::ST_EMPTY;
                end else if (w_idx >= r_count) begin
                    w_st = ile_pkg::ST_BAD_INDEX;
                end else begin
                    w_ctl.wr = w_acc;
                end
            end
            ile_pkg::OP_APPEND: begin
                if (w_full) begin
                    w_st = ile_pkg::ST_FULL;
                end else begin
                    w_ctl.wr  = w_acc;
                    w_ctl.pos = ile_pkg::ADDR_W'(r_count);
                    n_count   = r_count + ile_pkg::CNT_W'(1);
                end
            end
            ile_pkg::OP_REMOVE_LAST: begin
                if (w_empty) begin
                    w_st = ile_pkg::ST_EMPTY;
                end else begin
                    w_res   = w_sel;
                    n_count = r_count - ile_pkg::CNT_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    genvar g;
    generate
        for (g = 0; g < ile_pkg::CAPACITY; g++) begin : g_cell
            logic [ile_pkg::DATA_W-1:0] w_left;
            logic [ile_pkg::DATA_W-1:0] w_right;
            if (g == 0) begin : g_first
                assign w_left = '0;
            end else begin : g_mid_l
                assign w_left = w_cell_data[g-1];
            end
            if (g == ile_pkg::CAPACITY - 1) begin : g_last
                assign w_right = '0;
            end else begin : g_mid_r
                assign w_right = w_cell_data[g+1];
            end
            ile_cell u_cell (
                .i_clk      (i_clk),
                .i_id       (ile_pkg::ADDR_W'(g)),
                .i_ctl      (w_ctl),
                .i_left     (w_left),
                .i_right    (w_right),
                .o_data     (w_cell_data[g]),
                .o_hit_data (w_cell_hit[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_acc) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_out_data <= {(ile_pkg::OUT_W - 41)'(0), n_count, w_st, w_res};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

FILE: rtl/ile_cell.sv
module ile_cell (
    input  logic                        i_clk,
    input  logic [ile_pkg::ADDR_W-1:0]  i_id,
    input  ile_pkg::t_cell_ctl          i_ctl,
    input  logic [ile_pkg::DATA_W-1:0]  i_left,
    input  logic [ile_pkg::DATA_W-1:0]  i_right,
    output logic [ile_pkg::DATA_W-1:0]  o_data,
    output logic [ile_pkg::DATA_W-1:0]  o_hit_data
);

    logic [ile_pkg::DATA_W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.ins) begin
            if (i_id == i_ctl.pos) begin
                r_data <= i_ctl.data;
            end else if (i_id > i_ctl.pos) begin
                r_data <= i_left;
            end
        end else if (i_ctl.del) begin
            if (i_id >= i_ctl.pos) begin
                r_data <= i_right;
            end
        end else if (i_ctl.wr && (i_id == i_ctl.pos)) begin
            r_data <= i_ctl.data;
        end
    end

    assign o_data     = r_data;
    // masked so the row can be or-reduced
    assign o_hit_data = (i_id == i_ctl.rd_pos) ? r_data : '0;

endmodule

FILE: bench/tb_indexed_list_engine_unit.sv
`timescale 1ns / 1ps

module tb_indexed_list_engine_unit;

    // op codes that the block leaves alone
    localparam logic [ile_pkg::OP_W-1:0] OP_UNUSED_6 = 3'd6;
    localparam logic [ile_pkg::OP_W-1:0] OP_UNUSED_7 = 3'd7;

    localparam logic [ile_pkg::DATA_W-1:0] VAL_MIN = 32'h8000_0000;
    localparam logic [ile_pkg::DATA_W-1:0] VAL_MAX = 32'h7FFF_FFFF;

    typedef enum int {MIX_GROW, MIX_HOLD_FULL, MIX_SHRINK, MIX_EVEN} t_mix;

    localparam int SEGMENTS = 13;
    localparam t_mix PLAN [SEGMENTS] = '{MIX_GROW, MIX_GROW, MIX_HOLD_FULL, MIX_SHRINK,
        MIX_SHRINK, MIX_EVEN, MIX_GROW, MIX_HOLD_FULL, MIX_HOLD_FULL, MIX_SHRINK,
        MIX_EVEN, MIX_SHRINK, MIX_GROW};

    typedef struct packed {
        logic [ile_pkg::DATA_W-1:0] value;
        logic [ile_pkg::ST_W-1:0]   status;
        logic [ile_pkg::CNT_W-1:0]  count;
    } t_list_result;

    class list_scoreboard;
        logic [ile_pkg::DATA_W-1:0] cells [ile_pkg::CAPACITY];
        int                         n_items;
        t_list_result               expected_q [$];
        int                         failures;

        function new();
            n_items  = 0;
            failures = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // apply one accepted request to the list copy and queue its result
        function void note_request(logic [ile_pkg::OP_W-1:0] op,
                                   logic [ile_pkg::IDX_W-1:0] idx,
                                   logic [ile_pkg::DATA_W-1:0] val);
            t_list_result r;
            int i;
            r.value  = ile_pkg::NONE_VALUE;
            r.status = ile_pkg::ST_OK;
            case (op)
                ile_pkg::OP_INSERT: begin
                    if (idx > n_items) begin
                        r.status = ile_pkg::ST_BAD_INDEX;
                    end else if (n_items >= ile_pkg::CAPACITY) begin
                        r.status = ile_pkg::ST_FULL;
                    end else begin
                        for (i = n_items; i > idx; i--) cells[i] = cells[i-1];
                        cells[idx] = val;
                        n_items++;
                    end
                end
                ile_pkg::OP_DELETE: begin
                    if (n_items == 0) begin
                        r.status = ile_pkg::ST_EMPTY;
                    end else if (idx >= n_items) begin
                        r.status = ile_pkg::ST_BAD_INDEX;
                    end else begin
                        r.value = cells[idx];
                        for (i = idx; i + 1 < n_items; i++) cells[i] = cells[i+1];
                        n_items--;
                    end
                end
                ile_pkg::OP_READ: begin
                    if (n_items == 0) r.status = ile_pkg::ST_EMPTY;
                    else if (idx >= n_items) r.status = ile_pkg::ST_BAD_INDEX;
                    else r.value = cells[idx];
                end
                ile_pkg::OP_REPLACE: begin
                    if (n_items == 0) r.status = ile_pkg::ST_EMPTY;
                    else if (idx >= n_items) r.status = ile_pkg::ST_BAD_INDEX;
                    else cells[idx] = val;
                end
                ile_pkg::OP_APPEND: begin
                    if (n_items >= ile_pkg::CAPACITY) begin
                        r.status = ile_pkg::ST_FULL;
                    end else begin
                        cells[n_items] = val;
                        n_items++;
                    end
                end
                ile_pkg::OP_REMOVE_LAST: begin
                    if (n_items == 0) begin
                        r.status = ile_pkg::ST_EMPTY;
                    end else begin
                        n_items--;
                        r.value = cells[n_items];
                    end
                end
                default: ;
            endcase
            r.count = ile_pkg::CNT_W'(n_items);
            expected_q.push_back(r);
        endfunction

        function void check_result(logic [ile_pkg::OUT_W-1:0] word);
            t_list_result got;
            t_list_result exp_r;
            got.value  = word[31:0];
            got.status = word[33:32];
            got.count  = word[40:34];
            if (expected_q.size() == 0) begin
                $error("unexpected result %h with no request outstanding", word);
                failures++;
                return;
            end
            exp_r = expected_q.pop_front();
            if (got.value !== exp_r.value) begin
                $error("result_value: expected %h, got %h", exp_r.value, got.value);
                failures++;
            end
            if (got.status !== exp_r.status) begin
                $error("status: expected %0d, got %0d", exp_r.status, got.status);
                failures++;
            end
            if (got.count !== exp_r.count) begin
                $error("count: expected %0d, got %0d", exp_r.count, got.count);
                failures++;
            end
        endfunction
    endclass

    logic                       clk;
    logic                       rst_n     = 1'b0;
    logic                       req_valid = 1'b0;
    logic                       req_ready;
    logic [ile_pkg::IN_W-1:0]   req_data  = '0;
    logic                       rsp_valid;
    logic                       rsp_ready = 1'b0;
    logic [ile_pkg::OUT_W-1:0]  rsp_data;

    list_scoreboard sb;
    int burst_left = 0;
    int rx_tick    = 0;
    int rx_mode    = 0;
    int rx_hold    = 0;

    indexed_list_engine_unit dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (req_valid),
        .o_s_axis_tready (req_ready),
        .i_s_axis_tdata  (req_data),
        .o_m_axis_tvalid (rsp_valid),
        .i_m_axis_tready (rsp_ready),
        .o_m_axis_tdata  (rsp_data)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    // result side stalls, in one of four randomly chosen styles
    always @(negedge clk) begin
        rx_tick++;
        if (rx_tick % 300 == 0) rx_mode = $urandom_range(3);
        case (rx_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(9) < 7);
            2: rsp_ready <= ($urandom_range(9) < 3);
            default: begin
                if (rx_hold > 0) begin
                    rx_hold--;
                    rsp_ready <= 1'b0;
                end else if ($urandom_range(7) == 0) begin
                    rx_hold = $urandom_range(1, 12);
                    rsp_ready <= 1'b0;
                end else begin
                    rsp_ready <= 1'b1;
                end
            end
        endcase
    end

    always @(posedge clk) begin
        if (rst_n && rsp_valid && rsp_ready) sb.check_result(rsp_data);
    end

    task automatic send_request(input logic [ile_pkg::OP_W-1:0] op,
                                input logic [ile_pkg::IDX_W-1:0] idx,
                                input logic [ile_pkg::DATA_W-1:0] val);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 8);
            @(negedge clk) req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
            burst_left = ($urandom_range(7) == 0) ? $urandom_range(80, 200)
                                                  : $urandom_range(1, 30);
        end
        burst_left--;
        @(negedge clk);
        req_valid <= 1'b1;
        req_data  <= {{(ile_pkg::IN_W - ile_pkg::OP_W - ile_pkg::IDX_W
                        - ile_pkg::DATA_W){1'b0}}, val, idx, op};
        do @(posedge clk); while (!req_ready);
        sb.note_request(op, idx, val);
    endtask

    task automatic wait_drained();
        @(negedge clk) req_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
    endtask

    function automatic logic [ile_pkg::OP_W-1:0] pick_op(t_mix mix);
        int r;
        int w_ins, w_app, w_del, w_rem;
        r = $urandom_range(99);
        case (mix)
            MIX_GROW:      begin w_ins = 35; w_app = 30; w_del = 6;  w_rem = 6;  end
            MIX_SHRINK:    begin w_ins = 5;  w_app = 5;  w_del = 35; w_rem = 30; end
            MIX_HOLD_FULL: begin w_ins = 25; w_app = 25; w_del = 8;  w_rem = 4;  end
            default:       begin w_ins = 17; w_app = 17; w_del = 17; w_rem = 17; end
        endcase
        if (r < 3) return (r == 0) ? OP_UNUSED_6 : OP_UNUSED_7;
        r -= 3;
        if (r < w_ins) return ile_pkg::OP_INSERT;
        r -= w_ins;
        if (r < w_app) return ile_pkg::OP_APPEND;
        r -= w_app;
        if (r < w_del) return ile_pkg::OP_DELETE;
        r -= w_del;
        if (r < w_rem) return ile_pkg::OP_REMOVE_LAST;
        r -= w_rem;
        return (r % 2 == 0) ? ile_pkg::OP_READ : ile_pkg::OP_REPLACE;
    endfunction

    // mostly legal positions, some on the boundary, some anywhere in the field
    function automatic logic [ile_pkg::IDX_W-1:0] pick_index(logic [ile_pkg::OP_W-1:0] op);
        int r;
        int n;
        r = $urandom_range(99);
        n = sb.n_items;
        if (r < 10) return ile_pkg::IDX_W'($urandom_range(127));
        if (r < 20) return ile_pkg::IDX_W'(n + $urandom_range(1));
        if (op == ile_pkg::OP_INSERT) return ile_pkg::IDX_W'($urandom_range(n));
        return (n > 0) ? ile_pkg::IDX_W'($urandom_range(n - 1)) : '0;
    endfunction

    function automatic logic [ile_pkg::DATA_W-1:0] pick_value();
        case ($urandom_range(9))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2:       return ile_pkg::NONE_VALUE;
            3:       return '0;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        logic [ile_pkg::OP_W-1:0] op;
        int done;
        sb = new();
        repeat (3) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        // empty list
        send_request(ile_pkg::OP_READ,        7'd0,   32'h1111_1111);
        send_request(ile_pkg::OP_DELETE,      7'd0,   32'h2222_2222);
        send_request(ile_pkg::OP_REPLACE,     7'd0,   32'h3333_3333);
        send_request(ile_pkg::OP_REMOVE_LAST, 7'd0,   32'h4444_4444);
        send_request(ile_pkg::OP_INSERT,      7'd1,   32'h5555_5555);
        // build a short list through every write path
        send_request(ile_pkg::OP_INSERT,      7'd0,   VAL_MAX);
        send_request(ile_pkg::OP_INSERT,      7'd0,   VAL_MIN);
        send_request(ile_pkg::OP_APPEND,      7'd127, ile_pkg::NONE_VALUE);
        send_request(ile_pkg::OP_APPEND,      7'd0,   32'h0);
        send_request(ile_pkg::OP_INSERT,      7'd2,   32'h1234_5678);
        send_request(ile_pkg::OP_READ,        7'd0,   32'h0);
        send_request(ile_pkg::OP_READ,        7'd4,   32'h0);
        send_request(ile_pkg::OP_READ,        7'd5,   32'h0);
        send_request(ile_pkg::OP_READ,        7'd127, 32'h0);
        send_request(ile_pkg::OP_REPLACE,     7'd4,   32'hA5A5_A5A5);
        send_request(ile_pkg::OP_REPLACE,     7'd64,  32'h5A5A_5A5A);
        send_request(ile_pkg::OP_DELETE,      7'd2,   32'h0);
        send_request(ile_pkg::OP_DELETE,      7'd0,   32'h0);
        send_request(ile_pkg::OP_DELETE,      7'd5,   32'h0);
        send_request(ile_pkg::OP_REMOVE_LAST, 7'd99,  32'h0);
        send_request(OP_UNUSED_6,             7'd127, ile_pkg::NONE_VALUE);
        send_request(OP_UNUSED_7,             7'd0,   32'h0);
        send_request(ile_pkg::OP_INSERT,      7'd127, 32'hDEAD_BEEF);
        send_request(ile_pkg::OP_DELETE,      7'd1,   32'h0);
        send_request(ile_pkg::OP_READ,        7'd0,   32'h0);

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            if (seg == 3 || $urandom_range(3) == 0) wait_drained();
            done = 0;
            while (done < 100) begin
                op = pick_op(PLAN[seg]);
                send_request(op, pick_index(op), pick_value());
                if (op != OP_UNUSED_6 && op != OP_UNUSED_7) done++;
            end
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (sb.failures == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
